// File: src/psd_pkg.sv
package psd_pkg;

	// classified payload beat handed from the parser to the output side
	typedef struct packed {
		logic [7:0] data;
		logic       kind;   // 0 video, 1 audio
		logic       first;  // first audio payload byte of a pes
	} beat_t;

	// default depth of the queue between parser and output side
	localparam int QUEUE_DEPTH = 4;

	// out_kind codes
	localparam logic KIND_VIDEO = 1'b0;
	localparam logic KIND_AUDIO = 1'b1;

	// nal unit type field and the key unit types
	localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
	localparam logic [4:0] NAL_IDR       = 5'd5;
	localparam logic [4:0] NAL_SPS       = 5'd7;
	localparam logic [4:0] NAL_PPS       = 5'd8;

endpackage

// File: src/psd_front.sv
module psd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	output logic                push_valid,
	input  logic                push_ready,
	output psd_pkg::beat_t      push_beat
);

	// parse phase codes
	localparam logic [3:0] PH_SYNC    = 4'd0;
	localparam logic [3:0] PH_ID      = 4'd1;
	localparam logic [3:0] PH_PACK    = 4'd2;
	localparam logic [3:0] PH_SKIP    = 4'd3;
	localparam logic [3:0] PH_LEN_HI  = 4'd4;
	localparam logic [3:0] PH_LEN_LO  = 4'd5;
	localparam logic [3:0] PH_PLEN_HI = 4'd6;
	localparam logic [3:0] PH_PLEN_LO = 4'd7;
	localparam logic [3:0] PH_PHDR    = 4'd8;
	localparam logic [3:0] PH_POPT    = 4'd9;
	localparam logic [3:0] PH_PAYLOAD = 4'd10;

	// stream ids
	localparam logic [7:0] ID_PACK      = 8'hBA;
	localparam logic [7:0] ID_SYS_HDR   = 8'hBB;
	localparam logic [7:0] ID_MAP       = 8'hBC;
	localparam logic [7:0] ID_PRIVATE   = 8'hBD;
	localparam logic [7:0] ID_AUDIO_LO  = 8'hC0;
	localparam logic [7:0] ID_AUDIO_HI  = 8'hDF;
	localparam logic [7:0] ID_VIDEO_LO  = 8'hE0;
	localparam logic [7:0] ID_VIDEO_HI  = 8'hEF;
	localparam logic [7:0] PACK_HDR_LEN = 8'd10;
	localparam logic [7:0] PES_HDR_LEN  = 8'd3;

	logic [3:0]  phase_q, phase_n;
	logic [1:0]  zrun_q, zrun_n;
	logic [7:0]  sid_q, sid_n;
	logic [15:0] rem_q, rem_n;
	logic [7:0]  hdr_q, hdr_n;
	logic        afp_q, afp_n;
	logic [15:0] rem_dec;
	logic [7:0]  hdr_dec;
	logic        is_video;
	logic        accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	assign rem_dec  = (rem_q != 16'd0) ? 16'(rem_q - 16'd1) : rem_q;
	assign hdr_dec  = (hdr_q != 8'd0) ? 8'(hdr_q - 8'd1) : hdr_q;
	assign is_video = (sid_q inside {[ID_VIDEO_LO:ID_VIDEO_HI]});

	// next parse state and payload classification for the incoming byte
	always_comb begin
		phase_n    = phase_q;
		zrun_n     = zrun_q;
		sid_n      = sid_q;
		rem_n      = rem_q;
		hdr_n      = hdr_q;
		afp_n      = afp_q;
		push_valid = 1'b0;
		push_beat.data  = in_byte;
		push_beat.kind  = is_video ? psd_pkg::KIND_VIDEO : psd_pkg::KIND_AUDIO;
		push_beat.first = !is_video && afp_q;
		case (phase_q)
			PH_ID: begin
				sid_n  = in_byte;
				zrun_n = 2'd0;
				if (in_byte == ID_PACK) begin
					hdr_n   = PACK_HDR_LEN;
					phase_n = PH_PACK;
				end else if (in_byte inside {ID_SYS_HDR, ID_MAP, ID_PRIVATE}) begin
					phase_n = PH_LEN_HI;
				end else if (in_byte inside {[ID_AUDIO_LO:ID_VIDEO_HI]}) begin
					phase_n = PH_PLEN_HI;
				end else begin
					zrun_n  = (in_byte == 8'd0) ? 2'd1 : 2'd0;
					phase_n = PH_SYNC;
				end
			end
			PH_PACK: begin
				hdr_n = hdr_dec;
				if (hdr_dec == 8'd0) begin
					rem_n   = {13'd0, in_byte[2:0]};
					phase_n = (in_byte[2:0] != 3'd0) ? PH_SKIP : PH_SYNC;
				end
			end
			PH_SKIP: begin
				rem_n = rem_dec;
				if (rem_dec == 16'd0) begin
					phase_n = PH_SYNC;
				end
			end
			PH_LEN_HI, PH_PLEN_HI: begin
				rem_n   = {in_byte, 8'd0};
				phase_n = 4'(phase_q + 4'd1);
			end
			PH_LEN_LO: begin
				rem_n   = {rem_q[15:8], in_byte};
				phase_n = ({rem_q[15:8], in_byte} != 16'd0) ? PH_SKIP : PH_SYNC;
			end
			PH_PLEN_LO: begin
				rem_n = {rem_q[15:8], in_byte};
				if ({rem_q[15:8], in_byte} == 16'd0) begin
					phase_n = PH_SYNC;
				end else begin
					hdr_n   = PES_HDR_LEN;
					phase_n = PH_PHDR;
				end
			end
			PH_PHDR: begin
				rem_n = 16'(rem_q - 16'd1);
				hdr_n = hdr_dec;
				if (rem_n == 16'd0) begin
					phase_n = PH_SYNC;
				end else if (hdr_dec == 8'd0) begin
					hdr_n   = in_byte;
					afp_n   = (sid_q inside {[ID_AUDIO_LO:ID_AUDIO_HI]});
					phase_n = (in_byte != 8'd0) ? PH_POPT : PH_PAYLOAD;
				end
			end
			PH_POPT: begin
				rem_n = 16'(rem_q - 16'd1);
				hdr_n = hdr_dec;
				if (rem_n == 16'd0) begin
					phase_n = PH_SYNC;
				end else if (hdr_dec == 8'd0) begin
					phase_n = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				rem_n      = rem_dec;
				push_valid = in_valid;
				if (rem_dec == 16'd0) begin
					phase_n = PH_SYNC;
				end
				if (!is_video) begin
					afp_n = 1'b0;
				end
			end
			default: begin
				// start code hunt
				phase_n = PH_SYNC;
				if (in_byte == 8'd0) begin
					if (zrun_q < 2'd2) begin
						zrun_n = 2'(zrun_q + 2'd1);
					end
				end else if (in_byte == 8'd1 && zrun_q >= 2'd2) begin
					zrun_n  = 2'd0;
					phase_n = PH_ID;
				end else begin
					zrun_n = 2'd0;
				end
			end
		endcase
	end

	// parser state, updated on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			zrun_q  <= 2'd0;
			sid_q   <= 8'd0;
			rem_q   <= 16'd0;
			hdr_q   <= 8'd0;
			afp_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			zrun_q  <= zrun_n;
			sid_q   <= sid_n;
			rem_q   <= rem_n;
			hdr_q   <= hdr_n;
			afp_q   <= afp_n;
		end
	end

	// payload is only pushed from the payload phase
	a_push_phase: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> phase_q == PH_PAYLOAD)
		else $error("payload push outside payload phase");

	// a first-byte mark never goes with video
	a_first_audio: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_beat.first |-> push_beat.kind == psd_pkg::KIND_AUDIO)
		else $error("first mark on video beat");

endmodule

// File: src/psd_queue.sv
module psd_queue #(
	parameter int Depth = psd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  psd_pkg::beat_t push_beat,
	output logic           pop_valid,
	input  logic           pop_ready,
	output psd_pkg::beat_t pop_beat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	psd_pkg::beat_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign push_ready = (cnt_q != FullCnt);
	assign pop_valid  = (cnt_q != '0);
	assign pop_beat   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= CntW'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CntW'(cnt_q - 1'b1);
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FullCnt)
		else $error("queue count beyond depth");

	// count and pointers agree when the queue is empty
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with empty count");

endmodule

// File: src/psd_back.sv
module psd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  psd_pkg::beat_t pop_beat,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_kind,
	output logic           unit_start,
	output logic           key_unit
);

	logic [7:0] w0_q, w1_q, w2_q, w3_q;
	logic [2:0] fill_q;
	logic [1:0] skip_q;
	logic       open_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_kind_q, unit_start_q, key_unit_q;
	logic       do_pop, is_video, win_full;
	logic       sc3, sc4;
	logic [4:0] nal_type;
	logic       nal_key;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_kind   = out_kind_q;
	assign unit_start = unit_start_q;
	assign key_unit   = key_unit_q;

	assign pop_ready = !out_valid_q || out_ready;
	assign do_pop    = pop_valid && pop_ready;
	assign is_video  = (pop_beat.kind == psd_pkg::KIND_VIDEO);
	assign win_full  = (fill_q == 3'd4);

	// nal start code test on the window, nal type from the window or the new byte
	assign sc3 = (skip_q == 2'd0) && (w0_q == 8'd0) && (w1_q == 8'd0) && (w2_q == 8'd1);
	assign sc4 = (skip_q == 2'd0) && (w0_q == 8'd0) && (w1_q == 8'd0) && (w2_q == 8'd0)
		&& (w3_q == 8'd1);
	assign nal_type = sc3 ? w3_q[4:0] & psd_pkg::NAL_TYPE_MASK[4:0]
		: pop_beat.data[4:0] & psd_pkg::NAL_TYPE_MASK[4:0];
	assign nal_key  = (nal_type == psd_pkg::NAL_IDR) || (nal_type == psd_pkg::NAL_SPS)
		|| (nal_type == psd_pkg::NAL_PPS);

	// video window bytes
	always_ff @(posedge clk) begin
		if (do_pop && is_video) begin
			if (win_full) begin
				w0_q <= w1_q;
				w1_q <= w2_q;
				w2_q <= w3_q;
				w3_q <= pop_beat.data;
			end else begin
				case (fill_q[1:0])
					2'd0: w0_q <= pop_beat.data;
					2'd1: w1_q <= pop_beat.data;
					2'd2: w2_q <= pop_beat.data;
					default: w3_q <= pop_beat.data;
				endcase
			end
		end
	end

	// window control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= 3'd0;
			skip_q      <= 2'd0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				if (!is_video) begin
					out_valid_q <= 1'b1;
				end else if (!win_full) begin
					fill_q      <= 3'(fill_q + 3'd1);
					out_valid_q <= 1'b0;
				end else begin
					if (skip_q != 2'd0) begin
						skip_q <= 2'(skip_q - 2'd1);
					end else if (sc3) begin
						skip_q <= 2'd2;
					end else if (sc4) begin
						skip_q <= 2'd3;
					end
					if (sc3 || sc4) begin
						open_q <= 1'b1;
					end
					out_valid_q <= open_q || sc3 || sc4;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (do_pop) begin
			if (!is_video) begin
				out_byte_q   <= pop_beat.data;
				out_kind_q   <= psd_pkg::KIND_AUDIO;
				unit_start_q <= pop_beat.first;
				key_unit_q   <= 1'b0;
			end else begin
				out_byte_q   <= w0_q;
				out_kind_q   <= psd_pkg::KIND_VIDEO;
				unit_start_q <= sc3 || sc4;
				key_unit_q   <= (sc3 || sc4) && nal_key;
			end
		end
	end

	a_key_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && key_unit_q |-> unit_start_q)
		else $error("key unit without unit start");

	a_audio_nokey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == psd_pkg::KIND_AUDIO |-> !key_unit_q)
		else $error("key unit on audio");

	// no video result before a nal unit has been opened
	a_video_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == psd_pkg::KIND_VIDEO |-> open_q)
		else $error("video byte before first nal start code");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'd4)
		else $error("window fill out of range");

endmodule

// File: src/ps_demux_h264_nal_splitter.sv
// Program stream demultiplexer with h.264 nal splitting. Takes one raw program
// stream byte per beat and sustains one byte per clock while the queue is not
// full: a parser front end classifies each byte in the cycle it is taken, a
// small queue (QueueDepth beats) decouples it from the output side, and the
// output side holds one registered result. A payload byte passes through the
// queue and then the output register; headers and skipped packets produce
// nothing. Video bytes pass through a four-byte nal start code window, so the
// last four video bytes stay inside the block until further video payload
// pushes them out. Audio bytes leave directly with the first payload byte of
// each pes marked. There is no clearing pass after reset.
module ps_demux_h264_nal_splitter #(
	parameter int QueueDepth = psd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_kind,
	output logic       unit_start,
	output logic       key_unit
);

	logic           push_valid, push_ready;
	psd_pkg::beat_t push_beat;
	logic           pop_valid, pop_ready;
	psd_pkg::beat_t pop_beat;

	// stream parser
	psd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_beat  (push_beat)
	);

	// payload beat queue
	psd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_beat  (push_beat),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_beat   (pop_beat)
	);

	// nal window and output register
	psd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_beat   (pop_beat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.unit_start (unit_start),
		.key_unit   (key_unit)
	);

endmodule
